>>> design/dq_pkg.sv
// Shared constants, codes and the ring memory request type for the deque unit.
// No dependencies; used by dq_ring.sv and double_ended_queue_unit.sv.
`default_nettype none

package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = OCC_W + 1;
	localparam int ACT_W  = 3;
	localparam int STAT_W = 2;

	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [IDX_W-1:0]  addr;
		logic [DATA_W-1:0] wr_data;
	} ram_req_t;

endpackage

`default_nettype wire

>>> design/dq_ring.sv
// Ring storage for the deque: one shared port, registered read data.
// Depends on dq_pkg.sv.
`default_nettype none

module dq_ring (
	input  wire logic                      clk,
	input  wire dq_pkg::ram_req_t          req,
	output logic [dq_pkg::DATA_W-1:0]      rd_data
);

	logic [dq_pkg::DATA_W-1:0] mem_q [dq_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[req.addr];
		end
	end

endmodule

`default_nettype wire

>>> design/double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: sequencer, slot adder, result register.
// Depends on dq_pkg.sv and dq_ring.sv.
//
// Usage:
//  - Input channel (in_valid/in_stall, action, value): one action per item.
//    in_stall is high whenever the block is busy with the previous item.
//  - Output channel (out_valid/out_stall, value_res, status, last): results
//    leave from a result register; last marks the final result of an item.
//  - A push result is valid in the cycle after accept; a pop or list
//    entry passes the registered ring read and then the result register.
//  - The block takes no new item before it is done with the current one;
//    the pace is set by the single ring port and one shared slot adder
//    used by every step of the sequencer.
//  - Undefined actions (5..7) are dropped with no result.
//  - While out_stall is high the result register holds; the block takes no
//    new item until the last result of the current item is taken.
//  - Reset (arst_n low) empties the queue at once; no clearing pass, the
//    ring contents are never read before written.
`default_nettype none

module double_ended_queue_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [dq_pkg::ACT_W-1:0]          action,
	input  wire logic signed [dq_pkg::DATA_W-1:0]  value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [dq_pkg::DATA_W-1:0]       value_res,
	output logic [dq_pkg::STAT_W-1:0]              status,
	output logic                                   last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	localparam logic [dq_pkg::SUM_W-1:0] DEPTH_S = dq_pkg::SUM_W'(dq_pkg::DEPTH);
	localparam logic [dq_pkg::OCC_W-1:0] DEPTH_O = dq_pkg::OCC_W'(dq_pkg::DEPTH);

	logic [1:0]                   state_q;
	logic [dq_pkg::IDX_W-1:0]     front_q;
	logic [dq_pkg::OCC_W-1:0]     occ_q;
	logic [dq_pkg::OCC_W-1:0]     cnt_q;
	logic [dq_pkg::ACT_W-1:0]     act_q;
	logic [dq_pkg::DATA_W-1:0]    res_value_q;
	logic [dq_pkg::STAT_W-1:0]    res_status_q;
	logic                         res_last_q;

	logic                         accept;
	logic                         take;
	logic                         is_full;
	logic                         is_empty;
	logic                         list_more;
	logic [dq_pkg::OCC_W-1:0]     offset;
	logic [dq_pkg::SUM_W-1:0]     slot_sum;
	logic [dq_pkg::IDX_W-1:0]     slot;
	dq_pkg::ram_req_t             ram_req;
	logic [dq_pkg::DATA_W-1:0]    rd_data;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign take      = out_valid && !out_stall;
	assign is_full   = (occ_q == DEPTH_O);
	assign is_empty  = (occ_q == '0);
	assign list_more = (act_q == dq_pkg::ACT_LIST) && !res_last_q;

	assign value_res = res_value_q;
	assign status    = res_status_q;
	assign last      = res_last_q;

	// offset into the ring from the front slot, per sequencer step
	always_comb begin
		offset = '0;
		unique case (state_q)
			S_IDLE: begin
				case (action)
					dq_pkg::ACT_PUSH_FRONT: offset = dq_pkg::OCC_W'(dq_pkg::DEPTH - 1);
					dq_pkg::ACT_PUSH_REAR:  offset = occ_q;
					dq_pkg::ACT_POP_REAR:   offset = dq_pkg::OCC_W'(occ_q - 1'b1);
					default:                offset = '0;
				endcase
			end
			S_RD:    offset = dq_pkg::OCC_W'(1);
			S_OUT:   offset = dq_pkg::OCC_W'(cnt_q + 1'b1);
			default: offset = '0;
		endcase
	end

	// shared slot adder with one wrap correction
	always_comb begin
		slot_sum = dq_pkg::SUM_W'(front_q) + dq_pkg::SUM_W'(offset);
		if (slot_sum >= DEPTH_S) begin
			slot_sum = slot_sum - DEPTH_S;
		end
		slot = slot_sum[dq_pkg::IDX_W-1:0];
	end

	always_comb begin
		ram_req.addr    = slot;
		ram_req.wr_data = value;
		ram_req.wr_en   = 1'b0;
		ram_req.rd_en   = 1'b0;
		if (accept) begin
			case (action) inside
				dq_pkg::ACT_PUSH_FRONT,
				dq_pkg::ACT_PUSH_REAR: ram_req.wr_en = !is_full;
				dq_pkg::ACT_POP_FRONT,
				dq_pkg::ACT_POP_REAR,
				dq_pkg::ACT_LIST:      ram_req.rd_en = !is_empty;
				default:               ram_req.rd_en = 1'b0;
			endcase
		end else if (take && list_more) begin
			ram_req.rd_en = 1'b1;
		end
	end

	dq_ring u_ring (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			occ_q   <= '0;
			cnt_q   <= '0;
			act_q   <= dq_pkg::ACT_PUSH_FRONT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= action;
						cnt_q <= '0;
						unique case (action) inside
							dq_pkg::ACT_PUSH_FRONT: begin
								state_q <= S_OUT;
								if (!is_full) begin
									front_q <= slot;
									occ_q   <= occ_q + 1'b1;
								end
							end
							dq_pkg::ACT_PUSH_REAR: begin
								state_q <= S_OUT;
								if (!is_full) begin
									occ_q <= occ_q + 1'b1;
								end
							end
							dq_pkg::ACT_POP_FRONT,
							dq_pkg::ACT_POP_REAR,
							dq_pkg::ACT_LIST: begin
								state_q <= is_empty ? S_OUT : S_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: begin
					state_q <= S_OUT;
					// pops retire here; front moves by one on a front pop
					if (act_q == dq_pkg::ACT_POP_FRONT) begin
						front_q <= slot;
						occ_q   <= occ_q - 1'b1;
					end else if (act_q == dq_pkg::ACT_POP_REAR) begin
						occ_q <= occ_q - 1'b1;
					end
				end
				S_OUT: begin
					if (take) begin
						if (list_more) begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_value_q <= '0;
			res_last_q  <= 1'b1;
			case (action) inside
				dq_pkg::ACT_PUSH_FRONT,
				dq_pkg::ACT_PUSH_REAR: res_status_q <= is_full ? dq_pkg::STAT_FULL
				                                               : dq_pkg::STAT_OK;
				default:               res_status_q <= dq_pkg::STAT_EMPTY;
			endcase
		end else if (state_q == S_RD) begin
			res_value_q  <= rd_data;
			res_status_q <= dq_pkg::STAT_OK;
			res_last_q   <= (act_q != dq_pkg::ACT_LIST) ||
			                (dq_pkg::OCC_W'(cnt_q + 1'b1) == occ_q);
		end
	end

`ifndef SYNTHESIS
	// no new item while a result is pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("item accepted while result pending");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_O)
		else $error("occupancy above depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == dq_pkg::STAT_FULL) |-> (is_full && last))
		else $error("full status without a full queue");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == dq_pkg::STAT_EMPTY) |-> (is_empty && last))
		else $error("empty status without an empty queue");
`endif

endmodule

`default_nettype wire
